// ===== rtl/core/pei_pkg.sv =====
`default_nettype none

package pei_pkg;

    localparam int MAX_SEG   = 16;
    localparam int SEG_IDX_W = $clog2(MAX_SEG);
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int TGT_W     = DATA_W + FRAC_W;   // deviate at hazard scale
    localparam int DCNT_W    = $clog2(TGT_W);
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME = 1'b0,
        CFG_SEG_COUNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAT       = 2'd1,
        ST_ZERO_RATE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SELECT,
        S_WALK_RD,
        S_WALK_MUL,
        S_WALK_ACC,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic draw;
        logic scan_chk;
        logic select;
        logic walk_rd;
        logic walk_mul;
        logic walk_acc;
        logic div_init;
        logic div_step;
        logic div_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic walk_more;
        logic prod_gt;
        logic rate_zero;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/pei_dpath.sv =====
`default_nettype none

module pei_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr,
    input  logic [pei_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pei_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic [pei_pkg::SEG_IDX_W-1:0]   i_segment_index,
    input  logic [pei_pkg::DATA_W-1:0]      i_segment_time,
    input  logic [pei_pkg::DATA_W-1:0]      i_segment_rate,
    input  logic [pei_pkg::DATA_W-1:0]      i_deviate,
    input  pei_pkg::t_cmd                   i_cmd,
    output pei_pkg::t_sts                   o_sts,
    output logic [pei_pkg::DATA_W-1:0]      o_draw_time,
    output logic [1:0]                      o_status
);
    import pei_pkg::*;

    // configuration
    logic [DATA_W-1:0]    r_st;
    logic [CNT_W-1:0]     r_cnt;

    // segment tables, registered read
    logic [DATA_W-1:0]    r_mem_time [MAX_SEG];
    logic [DATA_W-1:0]    r_mem_rate [MAX_SEG];
    logic [DATA_W-1:0]    r_time_q;
    logic [DATA_W-1:0]    r_rate_q;

    // walk state
    logic [SEG_IDX_W-1:0] r_i;
    logic [SEG_IDX_W-1:0] r_kscan;
    logic [DATA_W-1:0]    r_bt0;
    logic [DATA_W-1:0]    r_btlast;
    logic [DATA_W-1:0]    r_s;
    logic [DATA_W-1:0]    r_nxt;
    logic [TGT_W-1:0]     r_rem;
    logic [2*DATA_W-1:0]  r_prod;

    // divider
    logic [DATA_W-1:0]    r_rate;
    logic [DATA_W-1:0]    r_prem;
    logic [TGT_W-1:0]     r_quo;
    logic [DCNT_W-1:0]    r_dcnt;

    // result and output registers
    logic [DATA_W-1:0]    r_res_time;
    t_status              r_res_status;
    logic [DATA_W-1:0]    r_out_time;
    t_status              r_out_status;

    logic [CNT_W-1:0]     w_n;
    logic [CNT_W-1:0]     w_last;
    logic [SEG_IDX_W-1:0] w_addr_t;
    logic [DATA_W-1:0]    w_width;
    logic [2*DATA_W-1:0]  w_prod;
    logic [DATA_W:0]      w_shift;
    logic [DATA_W:0]      w_trial;
    logic                 w_fit;
    logic [TGT_W:0]       w_sum;

    // zero count reads as one, large counts clip to the table size
    always_comb begin
        if (r_cnt == '0) begin
            w_n = CNT_W'(1);
        end else if (r_cnt > CNT_W'(MAX_SEG)) begin
            w_n = CNT_W'(MAX_SEG);
        end else begin
            w_n = r_cnt;
        end
    end

    assign w_last   = w_n - CNT_W'(1);
    assign w_addr_t = i_cmd.walk_rd ? r_i + SEG_IDX_W'(1) : r_i;
    assign w_width  = (r_time_q > r_s) ? r_time_q - r_s : '0;
    assign w_prod   = {{DATA_W{1'b0}}, r_rate_q} * {{DATA_W{1'b0}}, w_width};
    assign w_shift  = {r_prem, r_quo[TGT_W-1]};
    assign w_trial  = w_shift - {1'b0, r_rate};
    assign w_fit    = (w_shift >= {1'b0, r_rate});
    assign w_sum    = {{(TGT_W-DATA_W+1){1'b0}}, r_s} + {1'b0, r_quo};

    assign o_sts.scan_last = ({1'b0, r_i} == w_last);
    assign o_sts.walk_more = (({1'b0, r_i} + CNT_W'(1)) < w_n);
    assign o_sts.prod_gt   = (r_prod > {{(2*DATA_W-TGT_W){1'b0}}, r_rem});
    assign o_sts.rate_zero = (r_rate_q == '0);
    assign o_sts.div_last  = (r_dcnt == DCNT_W'(TGT_W-1));

    assign o_draw_time = r_out_time;
    assign o_status    = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_cnt <= CNT_W'(1);
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_TIME: r_st  <= i_cfg_data;
                CFG_SEG_COUNT:  r_cnt <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem_time[i_segment_index] <= i_segment_time;
            r_mem_rate[i_segment_index] <= i_segment_rate;
        end
        r_time_q <= r_mem_time[w_addr_t];
        r_rate_q <= r_mem_rate[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw) begin
            r_rem <= {i_deviate, {FRAC_W{1'b0}}};
            r_i   <= '0;
        end

        if (i_cmd.scan_chk) begin
            if (r_i == '0) begin
                r_bt0 <= r_time_q;
            end
            r_btlast <= r_time_q;   // holds the last entry once the scan ends
            if (r_time_q < r_st) begin
                r_kscan <= r_i;
            end
            if (!o_sts.scan_last) begin
                r_i <= r_i + SEG_IDX_W'(1);
            end
        end

        if (i_cmd.select) begin
            if ((w_n == CNT_W'(1)) || (r_st > r_btlast)) begin
                r_i <= w_last[SEG_IDX_W-1:0];
                r_s <= r_st;
            end else if (r_st > r_bt0) begin
                r_i <= r_kscan;
                r_s <= r_st;
            end else begin
                r_i <= '0;
                r_s <= r_bt0;
            end
        end

        if (i_cmd.walk_mul) begin
            r_prod <= w_prod;
            r_nxt  <= r_time_q;
        end

        if (i_cmd.walk_acc && !o_sts.prod_gt) begin
            r_rem <= r_rem - r_prod[TGT_W-1:0];
            if (r_nxt > r_s) begin
                r_s <= r_nxt;
            end
            r_i <= r_i + SEG_IDX_W'(1);
        end

        if (i_cmd.div_init) begin
            r_rate <= r_rate_q;
            r_prem <= '0;
            r_quo  <= r_rem;
            r_dcnt <= '0;
            if (o_sts.rate_zero) begin
                r_res_time   <= '1;
                r_res_status <= ST_ZERO_RATE;
            end
        end

        if (i_cmd.div_step) begin
            if (w_fit) begin
                r_prem <= w_trial[DATA_W-1:0];
                r_quo  <= {r_quo[TGT_W-2:0], 1'b1};
            end else begin
                r_prem <= w_shift[DATA_W-1:0];
                r_quo  <= {r_quo[TGT_W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end

        if (i_cmd.div_end) begin
            if (w_sum[TGT_W:DATA_W] != '0) begin
                r_res_time   <= '1;
                r_res_status <= ST_SAT;
            end else begin
                r_res_time   <= w_sum[DATA_W-1:0];
                r_res_status <= ST_OK;
            end
        end

        if (i_cmd.load) begin
            r_res_time   <= '0;
            r_res_status <= ST_OK;
        end

        if (i_cmd.out_load) begin
            r_out_time   <= r_res_time;
            r_out_status <= r_res_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pei_ctrl.sv =====
`default_nettype none

module pei_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    input  logic          i_out_stall,
    input  pei_pkg::t_sts i_sts,
    output pei_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import pei_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_DRAW) begin
                        o_cmd.draw = 1'b1;
                        n_state    = S_SCAN_RD;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DONE;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state        = i_sts.scan_last ? S_SELECT : S_SCAN_RD;
            end
            S_SELECT: begin
                o_cmd.select = 1'b1;
                n_state      = S_WALK_RD;
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = i_sts.walk_more ? S_WALK_MUL : S_DIV_INIT;
            end
            S_WALK_MUL: begin
                o_cmd.walk_mul = 1'b1;
                n_state        = S_WALK_ACC;
            end
            S_WALK_ACC: begin
                o_cmd.walk_acc = 1'b1;
                n_state        = i_sts.prod_gt ? S_DIV_INIT : S_WALK_RD;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = i_sts.rate_zero ? S_DONE : S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                n_state        = i_sts.div_last ? S_DIV_END : S_DIV_STEP;
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_draw_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_DRAW) |=> (r_state == S_SCAN_RD))
        else $error("draw transfer did not start the table scan");

    a_div_runs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_STEP && !i_sts.div_last) |=> (r_state == S_DIV_STEP))
        else $error("divider left before its last step");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output became valid outside the done state");

    a_mul_needs_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_MUL) |-> $past(i_sts.walk_more))
        else $error("hazard product taken past the last segment");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/piecewise_exponential_inverse.sv =====
`default_nettype none

// Piecewise exponential sampler by inverse cumulative hazard, Q16.16 throughout.
// A load (action 0) writes one segment entry, a breakpoint time and a rate, and
// returns a zero result; a draw (action 1) takes a unit exponential deviate and
// returns the event time, starting at the configured start time (at the first
// breakpoint instead when more than one segment is in use and it is later),
// walking the segments and dividing the leftover hazard by the final segment's
// rate. Status is 0 ok, 1 saturated to all ones, 2 zero rate in the final
// segment (time all ones). Segment entries read by a draw must have been loaded
// first. A draw works in steps: a scan of n table reads, for n segments in use,
// picks the start segment, each segment passed by the walk costs a table read,
// a 32x32 multiply and a hazard update, and the final division by the rate
// runs one quotient bit per cycle over 48 bits and is skipped when the final
// rate is zero. Items are taken one at a time; the next item is accepted while
// a finished result still waits in the output register. Configuration
// transfers are always taken (ready tied high) and must only be made while the
// block is idle.

module piecewise_exponential_inverse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pei_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pei_pkg::DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [pei_pkg::SEG_IDX_W-1:0]   i_segment_index,
    input  logic [pei_pkg::DATA_W-1:0]      i_segment_time,
    input  logic [pei_pkg::DATA_W-1:0]      i_segment_rate,
    input  logic [pei_pkg::DATA_W-1:0]      i_deviate,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pei_pkg::DATA_W-1:0]      o_draw_time,
    output logic [1:0]                      o_status
);
    import pei_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_wr;

    // registers are plain flops, so a write can always land
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    pei_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // tables, hazard walk, multiplier, serial divider and output register
    pei_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (w_cfg_wr),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_segment_index (i_segment_index),
        .i_segment_time  (i_segment_time),
        .i_segment_rate  (i_segment_rate),
        .i_deviate       (i_deviate),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_draw_time     (o_draw_time),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire
